// ----- src/lpfr_pkg.sv -----
// Package for the LRU page frame replacer: field widths, sequencer states and
// the recency-table command type.
// No dependencies; every other file of the block imports it.
`default_nettype none

package lpfr_pkg;

  // Fixed field widths of the ports
  localparam int CfgW      = 5;
  localparam int PagePortW = 16;
  localparam int FrameIdxW = 4;
  localparam int FaultW    = 32;

  // Reset value of the frames-in-use register
  localparam logic [CfgW-1:0] FramesInUseRst = 5'd16;

  // Fault counter saturation value (all ones)
  localparam logic [FaultW-1:0] FaultMax = '1;

  // Sequencer states
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate
  } lpfr_state_e;

  // Command from the sequencer to the recency table
  typedef struct packed {
    logic touch;  // make the selected frame most recent, age the others
    logic hit;    // age only frames younger than the selected one
    logic fill;   // mark the selected frame as occupied
  } rank_cmd_t;

endpackage

`default_nettype wire

// ----- src/lpfr_req_if.sv -----
// Request channel of the LRU page frame replacer: one page reference per item.
// Depends on lpfr_pkg for the page width.
`default_nettype none

interface lpfr_req_if import lpfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PagePortW-1:0] page;

  modport source (output valid, output page, input ready);
  modport sink (input valid, input page, output ready);
endinterface

`default_nettype wire

// ----- src/lpfr_rsp_if.sv -----
// Result channel of the LRU page frame replacer: one result item per reference.
// Depends on lpfr_pkg for the field widths.
`default_nettype none

interface lpfr_rsp_if import lpfr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [FrameIdxW-1:0] frame_index;
  logic                 evicted_valid;
  logic [PagePortW-1:0] evicted_page;
  logic [FaultW-1:0]    fault_total;

  modport source (output valid, output hit, output frame_index, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink (input valid, input hit, input frame_index, input evicted_valid,
                input evicted_page, input fault_total, output ready);
endinterface

`default_nettype wire

// ----- src/lpfr_page_ram.sv -----
// Page number store of the LRU page frame replacer: one write port and one
// read port with registered read data. Depends on lpfr_pkg only by convention.
`default_nettype none

module lpfr_page_ram import lpfr_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 16,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ----- src/lpfr_rank_table.sv -----
// Recency table of the LRU page frame replacer: one valid bit and one rank per
// frame, updated together on a touch. Depends on lpfr_pkg for rank_cmd_t.
`default_nettype none

module lpfr_rank_table import lpfr_pkg::*; #(
  parameter int FRAMES = 16,
  localparam int IdxW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  localparam int CntW = $clog2(FRAMES + 1)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire rank_cmd_t       cmd_i,
  input  wire logic [IdxW-1:0] sel_i,
  input  wire logic [CntW-1:0] cnt_i,
  input  wire logic [IdxW-1:0] rd_idx_i,
  output logic                 rd_valid_o,
  output logic      [IdxW-1:0] rd_rank_o
);

  localparam logic [IdxW-1:0] RankMax = IdxW'(FRAMES - 1);

  logic [FRAMES-1:0] valid_q, valid_d;
  logic [IdxW-1:0]   rank_q [FRAMES];
  logic [IdxW-1:0]   rank_d [FRAMES];
  logic [IdxW-1:0]   sel_rank;

  // Lookup for the frame under comparison
  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_rank_o  = rank_q[rd_idx_i];
  assign sel_rank   = rank_q[sel_i];

  // Touch: clear the selected rank, age the active valid frames below the limit
  always_comb begin
    valid_d = valid_q;
    for (int j = 0; j < FRAMES; j++) begin
      rank_d[j] = rank_q[j];
      if (cmd_i.touch) begin
        if (IdxW'(j) == sel_i) begin
          rank_d[j] = '0;
          if (cmd_i.fill) begin
            valid_d[j] = 1'b1;
          end
        end else if (valid_q[j] && (CntW'(j) < cnt_i) &&
                     (!cmd_i.hit || (rank_q[j] < sel_rank)) &&
                     (rank_q[j] != RankMax)) begin
          rank_d[j] = rank_q[j] + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      for (int j = 0; j < FRAMES; j++) begin
        rank_q[j] <= '0;
      end
    end else begin
      valid_q <= valid_d;
      for (int j = 0; j < FRAMES; j++) begin
        rank_q[j] <= rank_d[j];
      end
    end
  end

  // The touched frame becomes the most recent
  a_touch_clears_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.touch |=> rank_q[$past(sel_i)] == '0)
    else $error("touched frame did not become most recent");

  // A fill leaves the selected frame occupied
  a_fill_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.touch && cmd_i.fill |=> valid_q[$past(sel_i)])
    else $error("filled frame not marked occupied");

  // Without a fill the occupancy never changes
  a_valid_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.touch && cmd_i.fill) |=> valid_q == $past(valid_q))
    else $error("occupancy changed without a fill");

endmodule

`default_nettype wire

// ----- src/lru_page_frame_replacer.sv -----
// LRU page frame replacer: a fully associative table of FRAMES page frames
// of which frames_in_use take part. Each reference item is walked against the
// frames one per cycle by a single page comparator fed from the page store's
// read port, so the block takes one item at a time: a miss walks all active
// frames, and a hit ends the walk at the matching frame. A miss fills the
// lowest empty frame, or else replaces the least recently used one (lowest
// number on a tie). The result sits in an output register, so the next item
// is taken while it waits; the commit of that next item then holds until the
// earlier result has been taken.
// frames_in_use of 0 acts as 1 and values above FRAMES act as FRAMES; write
// it only while no item is in flight. Depends on lpfr_pkg, lpfr_req_if,
// lpfr_rsp_if, lpfr_page_ram and lpfr_rank_table.
`default_nettype none

module lru_page_frame_replacer import lpfr_pkg::*; #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [CfgW-1:0] cfg_wdata_i,
  lpfr_req_if.sink             req_i,
  lpfr_rsp_if.source           rsp_o
);

  localparam int IdxW   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW   = $clog2(FRAMES + 1);
  localparam int StoreW = (PAGE_BITS < PagePortW) ? PAGE_BITS : PagePortW;
  localparam int CmpW   = (CntW > CfgW) ? CntW : CfgW;

  lpfr_state_e state_q, state_d;

  logic [CfgW-1:0]   frames_in_use_q;
  logic [CmpW-1:0]   fiu_ext;
  logic [CntW-1:0]   cnt;

  logic [StoreW-1:0] page_q, page_d;
  logic [CntW-1:0]   rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]   cmp_idx_q, cmp_idx_d;
  logic              hit_q, hit_d;
  logic [IdxW-1:0]   hit_idx_q, hit_idx_d;
  logic              emp_found_q, emp_found_d;
  logic [IdxW-1:0]   emp_idx_q, emp_idx_d;
  logic [IdxW-1:0]   best_idx_q, best_idx_d;
  logic [IdxW-1:0]   best_rank_q, best_rank_d;
  logic [StoreW-1:0] best_page_q, best_page_d;
  logic [FaultW-1:0] fault_q, fault_d;

  logic              rsp_vld_q, rsp_vld_d;
  logic              rsp_load;
  logic              rsp_hit_q;
  logic [IdxW-1:0]   rsp_idx_q;
  logic              rsp_ev_q;
  logic [StoreW-1:0] rsp_ev_page_q;
  logic [FaultW-1:0] rsp_fault_q;

  logic              ram_we;
  logic [StoreW-1:0] ram_rdata;
  logic [IdxW-1:0]   sel;
  logic              evict;
  logic              page_eq;
  logic              cmp_last;
  rank_cmd_t         rank_cmd;
  logic              rt_valid;
  logic [IdxW-1:0]   rt_rank;

  // Effective frame count
  always_comb begin
    fiu_ext = CmpW'(frames_in_use_q);
    if (frames_in_use_q == '0) begin
      cnt = CntW'(1);
    end else if (fiu_ext > CmpW'(FRAMES)) begin
      cnt = CntW'(FRAMES);
    end else begin
      cnt = CntW'(fiu_ext);
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_in_use_q <= FramesInUseRst;
    end else if (cfg_we_i) begin
      frames_in_use_q <= cfg_wdata_i;
    end
  end

  // Frame chosen for this item
  assign evict    = !hit_q && !emp_found_q;
  assign sel      = hit_q ? hit_idx_q : (emp_found_q ? emp_idx_q : best_idx_q);
  assign page_eq  = (ram_rdata == page_q);
  assign cmp_last = ((CntW'(cmp_idx_q) + CntW'(1)) == cnt);

  lpfr_page_ram #(
    .DEPTH (FRAMES),
    .WIDTH (StoreW)
  ) u_page_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (sel),
    .wdata_i (page_q),
    .raddr_i (rd_idx_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  lpfr_rank_table #(
    .FRAMES (FRAMES)
  ) u_rank_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (rank_cmd),
    .sel_i      (sel),
    .cnt_i      (cnt),
    .rd_idx_i   (cmp_idx_q),
    .rd_valid_o (rt_valid),
    .rd_rank_o  (rt_rank)
  );

  assign req_i.ready = (state_q == StIdle);

  // Sequencer: accept, walk the frames, then commit and load the result
  always_comb begin
    state_d     = state_q;
    page_d      = page_q;
    rd_idx_d    = rd_idx_q;
    cmp_vld_d   = cmp_vld_q;
    cmp_idx_d   = cmp_idx_q;
    hit_d       = hit_q;
    hit_idx_d   = hit_idx_q;
    emp_found_d = emp_found_q;
    emp_idx_d   = emp_idx_q;
    best_idx_d  = best_idx_q;
    best_rank_d = best_rank_q;
    best_page_d = best_page_q;
    fault_d     = fault_q;
    ram_we      = 1'b0;
    rank_cmd    = '0;
    rsp_load    = 1'b0;
    rsp_vld_d   = rsp_vld_q && !rsp_o.ready;

    case (state_q)
      StIdle: begin
        if (req_i.valid) begin
          page_d      = req_i.page[StoreW-1:0];
          rd_idx_d    = '0;
          cmp_vld_d   = 1'b0;
          hit_d       = 1'b0;
          emp_found_d = 1'b0;
          state_d     = StScan;
        end
      end

      StScan: begin
        // Issue the next frame read
        if (rd_idx_q < cnt) begin
          rd_idx_d  = rd_idx_q + CntW'(1);
          cmp_vld_d = 1'b1;
          cmp_idx_d = rd_idx_q[IdxW-1:0];
        end else begin
          cmp_vld_d = 1'b0;
        end
        // Compare the frame read last cycle
        if (cmp_vld_q) begin
          if (rt_valid && page_eq) begin
            hit_d     = 1'b1;
            hit_idx_d = cmp_idx_q;
            state_d   = StUpdate;
          end else begin
            if (!rt_valid && !emp_found_q) begin
              emp_found_d = 1'b1;
              emp_idx_d   = cmp_idx_q;
            end
            if ((cmp_idx_q == '0) || (rt_rank > best_rank_q)) begin
              best_idx_d  = cmp_idx_q;
              best_rank_d = rt_rank;
              best_page_d = ram_rdata;
            end
            if (cmp_last) begin
              state_d = StUpdate;
            end
          end
        end
      end

      StUpdate: begin
        // Commit once the output register is free
        if (!rsp_vld_q || rsp_o.ready) begin
          rank_cmd.touch = 1'b1;
          rank_cmd.hit   = hit_q;
          rank_cmd.fill  = !hit_q && emp_found_q;
          ram_we         = !hit_q;
          if (!hit_q && (fault_q != FaultMax)) begin
            fault_d = fault_q + FaultW'(1);
          end
          rsp_load  = 1'b1;
          rsp_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_idx_q    <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_q       <= 1'b0;
      hit_idx_q   <= '0;
      emp_found_q <= 1'b0;
      emp_idx_q   <= '0;
      best_idx_q  <= '0;
      fault_q     <= '0;
      rsp_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_idx_q    <= rd_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      hit_q       <= hit_d;
      hit_idx_q   <= hit_idx_d;
      emp_found_q <= emp_found_d;
      emp_idx_q   <= emp_idx_d;
      best_idx_q  <= best_idx_d;
      fault_q     <= fault_d;
      rsp_vld_q   <= rsp_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    page_q      <= page_d;
    best_rank_q <= best_rank_d;
    best_page_q <= best_page_d;
    if (rsp_load) begin
      rsp_hit_q     <= hit_q;
      rsp_idx_q     <= sel;
      rsp_ev_q      <= evict;
      rsp_ev_page_q <= evict ? best_page_q : '0;
      rsp_fault_q   <= fault_d;
    end
  end

  // Drive the result channel
  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.hit           = rsp_hit_q;
  assign rsp_o.frame_index   = FrameIdxW'(rsp_idx_q);
  assign rsp_o.evicted_valid = rsp_ev_q;
  assign rsp_o.evicted_page  = PagePortW'(rsp_ev_page_q);
  assign rsp_o.fault_total   = rsp_fault_q;

  // The fault count only grows
  a_fault_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fault_q >= $past(fault_q))
    else $error("fault count decreased");

  // A hit never reports an eviction
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && rsp_o.hit |-> !rsp_o.evicted_valid)
    else $error("eviction reported on a hit");

  // No eviction means a zero evicted page
  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && !rsp_o.evicted_valid |-> rsp_o.evicted_page == '0)
    else $error("evicted page not zero without eviction");

  // The frame walk stays within the active frames
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StScan |-> rd_idx_q <= cnt)
    else $error("frame walk ran past the active frames");

endmodule

`default_nettype wire
